// ===== rtl/phc_pkg.sv =====
package phc_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int TIME_W     = 23;
   localparam int CODE_W     = 12;

   localparam logic [TIME_W-1:0] MIN_ON_US = TIME_W'(50);
   localparam logic [TIME_W-1:0] MAX_ON_US = TIME_W'(5000000);
   localparam logic [TIME_W-1:0] US_PER_MS = TIME_W'(1000);

   localparam logic [2:0] FUNC_FIRE      = 3'd0;
   localparam logic [2:0] FUNC_ABORT     = 3'd1;
   localparam logic [2:0] FUNC_ABORT_ALL = 3'd2;
   localparam logic [2:0] FUNC_TRIP      = 3'd3;
   localparam logic [2:0] FUNC_TICK      = 3'd4;

   localparam logic [2:0] KIND_ACCEPT  = 3'd0;
   localparam logic [2:0] KIND_REJECT  = 3'd1;
   localparam logic [2:0] KIND_HOLD    = 3'd2;
   localparam logic [2:0] KIND_TIMEOUT = 3'd3;
   localparam logic [2:0] KIND_ABORT   = 3'd4;

   localparam logic [2:0] CSR_PICK  = 3'd0;
   localparam logic [2:0] CSR_HOLD  = 3'd1;
   localparam logic [2:0] CSR_NZ    = 3'd2;
   localparam logic [2:0] CSR_DFLT0 = 3'd3;
   localparam logic [2:0] CSR_DFLT1 = 3'd4;
   localparam logic [2:0] CSR_DFLT2 = 3'd5;
   localparam logic [2:0] CSR_DFLT3 = 3'd6;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_PEAK = 2'd1,
      PH_HOLD = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CODE_W-1:0]                 pick;
      logic [CODE_W-1:0]                 hold;
      logic [CODE_W-1:0]                 nz;
      logic [SLOT_COUNT-1:0][TIME_W-1:0] dflt;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        gun_index;
      logic [2:0]        kind;
      logic [1:0]        phase;
      logic [CODE_W-1:0] dac_code;
      logic              coil_drive;
      logic              comp_route;
      logic              peak_irq_enable;
      logic              peak_seen;
      logic [TIME_W-1:0] time_us;
   } rec_type;

   function automatic rec_type zero_rec(input logic [1:0] gidx, input logic [2:0] kind);
      rec_type r;
      r           = '0;
      r.gun_index = gidx;
      r.kind      = kind;
      return r;
   endfunction

   function automatic rec_type build_rec(
      input logic [1:0]        gidx,
      input logic [2:0]        kind,
      input phase_type         ph,
      input logic [CODE_W-1:0] code,
      input logic              mux,
      input logic              flag,
      input logic [TIME_W-1:0] ptime,
      input logic [TIME_W-1:0] elapsed
   );
      rec_type r;
      r.gun_index       = gidx;
      r.kind            = kind;
      r.phase           = ph;
      r.dac_code        = code;
      r.coil_drive      = (ph == PH_PEAK) || (ph == PH_HOLD);
      r.comp_route      = mux;
      r.peak_irq_enable = (ph == PH_PEAK);
      r.peak_seen       = flag;
      r.time_us         = flag ? ptime : elapsed;
      return r;
   endfunction

endpackage

// ===== rtl/phc_core.sv =====
module phc_core #(
   parameter int GUN_COUNT = 4
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          advance,
   input  logic [2:0]                                    func,
   input  logic [2:0]                                    gun,
   input  logic [12:0]                                   on_time_ms,
   input  logic                                          system_armed,
   input  phc_pkg::cfg_type                              cfg,
   output phc_pkg::rec_type [phc_pkg::SLOT_COUNT-1:0]    load_rec,
   output logic [phc_pkg::SLOT_COUNT-1:0]                load_mask,
   output logic [GUN_COUNT-1:0]                          busy,
   output logic [GUN_COUNT-1:0]                          running
);
   import phc_pkg::*;

   phase_type         phase_ff   [GUN_COUNT];
   phase_type         phase_in   [GUN_COUNT];
   logic [TIME_W-1:0] remain_ff  [GUN_COUNT];
   logic [TIME_W-1:0] remain_in  [GUN_COUNT];
   logic              run_ff     [GUN_COUNT];
   logic              run_in     [GUN_COUNT];
   logic [TIME_W-1:0] elapsed_ff [GUN_COUNT];
   logic [TIME_W-1:0] elapsed_in [GUN_COUNT];
   logic              flag_ff    [GUN_COUNT];
   logic              flag_in    [GUN_COUNT];
   logic [TIME_W-1:0] ptime_ff   [GUN_COUNT];
   logic [TIME_W-1:0] ptime_in   [GUN_COUNT];
   logic              mux_ff     [GUN_COUNT];
   logic              mux_in     [GUN_COUNT];
   logic [CODE_W-1:0] code_ff    [GUN_COUNT];
   logic [CODE_W-1:0] code_in    [GUN_COUNT];

   logic [2:0]        slot_kind  [SLOT_COUNT];
   logic              gun_ok;
   logic              bad_fire;
   logic [TIME_W-1:0] ms_us;
   logic [TIME_W-1:0] want_us;
   logic [TIME_W-1:0] fire_us;

   assign gun_ok   = 32'(gun) < GUN_COUNT;
   assign bad_fire = (func == FUNC_FIRE) && !gun_ok;
   assign ms_us    = TIME_W'(on_time_ms) * US_PER_MS;
   assign want_us  = (on_time_ms != '0) ? ms_us : cfg.dflt[gun[1:0]];

   always_comb begin
      if (want_us < MIN_ON_US) begin
         fire_us = MIN_ON_US;
      end else if (want_us > MAX_ON_US) begin
         fire_us = MAX_ON_US;
      end else begin
         fire_us = want_us;
      end
   end

   always_comb begin
      logic              hit;
      logic [TIME_W-1:0] dec;
      load_mask = '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         slot_kind[s] = KIND_REJECT;
      end
      for (int g = 0; g < GUN_COUNT; g++) begin
         phase_in[g]   = phase_ff[g];
         remain_in[g]  = remain_ff[g];
         run_in[g]     = run_ff[g];
         elapsed_in[g] = elapsed_ff[g];
         flag_in[g]    = flag_ff[g];
         ptime_in[g]   = ptime_ff[g];
         mux_in[g]     = mux_ff[g];
         code_in[g]    = code_ff[g];
         hit           = gun_ok && (gun == 3'(g));
         dec           = remain_ff[g];
         case (func) inside
            FUNC_FIRE: begin
               if (hit) begin
                  load_mask[g] = 1'b1;
                  if (system_armed && phase_ff[g] == PH_IDLE) begin
                     slot_kind[g]  = KIND_ACCEPT;
                     phase_in[g]   = PH_PEAK;
                     code_in[g]    = cfg.pick;
                     mux_in[g]     = 1'b1;
                     elapsed_in[g] = '0;
                     flag_in[g]    = 1'b0;
                     ptime_in[g]   = '0;
                     remain_in[g]  = fire_us;
                     run_in[g]     = 1'b1;
                  end else begin
                     slot_kind[g] = KIND_REJECT;
                  end
               end
            end
            FUNC_ABORT, FUNC_ABORT_ALL: begin
               if ((hit || func == FUNC_ABORT_ALL) && phase_ff[g] != PH_IDLE) begin
                  load_mask[g] = 1'b1;
                  slot_kind[g] = KIND_ABORT;
                  run_in[g]    = 1'b0;
                  code_in[g]   = cfg.nz;
                  phase_in[g]  = PH_IDLE;
               end
            end
            FUNC_TRIP: begin
               if (hit && phase_ff[g] == PH_PEAK) begin
                  load_mask[g] = 1'b1;
                  slot_kind[g] = KIND_HOLD;
                  phase_in[g]  = PH_HOLD;
                  code_in[g]   = cfg.hold;
                  ptime_in[g]  = elapsed_ff[g];
                  flag_in[g]   = 1'b1;
               end
            end
            FUNC_TICK: begin
               if (run_ff[g]) begin
                  if (elapsed_ff[g] < MAX_ON_US) begin
                     elapsed_in[g] = elapsed_ff[g] + 1'b1;
                  end
                  if (remain_ff[g] != '0) begin
                     dec = remain_ff[g] - 1'b1;
                  end
                  remain_in[g] = dec;
                  if (dec == '0) begin
                     load_mask[g] = 1'b1;
                     slot_kind[g] = KIND_TIMEOUT;
                     run_in[g]    = 1'b0;
                     code_in[g]   = cfg.nz;
                     phase_in[g]  = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (bad_fire) begin
         load_mask[gun[1:0]] = 1'b1;
         slot_kind[gun[1:0]] = KIND_REJECT;
      end
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
      if (i < GUN_COUNT) begin : g_live
         assign load_rec[i] = bad_fire ? zero_rec(2'(i), slot_kind[i])
                            : build_rec(2'(i), slot_kind[i], phase_in[i], code_in[i],
                                        mux_in[i], flag_in[i], ptime_in[i], elapsed_in[i]);
      end else begin : g_none
         assign load_rec[i] = zero_rec(2'(i), slot_kind[i]);
      end
   end

   for (genvar g = 0; g < GUN_COUNT; g++) begin : g_gun
      assign busy[g]    = (phase_ff[g] != PH_IDLE);
      assign running[g] = run_ff[g];

      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[g]   <= PH_IDLE;
            remain_ff[g]  <= '0;
            run_ff[g]     <= 1'b0;
            elapsed_ff[g] <= '0;
            flag_ff[g]    <= 1'b0;
            ptime_ff[g]   <= '0;
            mux_ff[g]     <= 1'b0;
            code_ff[g]    <= '0;
         end else if (advance) begin
            phase_ff[g]   <= phase_in[g];
            remain_ff[g]  <= remain_in[g];
            run_ff[g]     <= run_in[g];
            elapsed_ff[g] <= elapsed_in[g];
            flag_ff[g]    <= flag_in[g];
            ptime_ff[g]   <= ptime_in[g];
            mux_ff[g]     <= mux_in[g];
            code_ff[g]    <= code_in[g];
         end
      end
   end

endmodule

// ===== rtl/phc_out.sv =====
module phc_out (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load,
   input  phc_pkg::rec_type [phc_pkg::SLOT_COUNT-1:0] load_rec,
   input  logic [phc_pkg::SLOT_COUNT-1:0]             load_mask,
   output logic                                       free,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output phc_pkg::rec_type                           rsp_rec,
   output logic                                       rsp_last
);
   import phc_pkg::*;

   rec_type [SLOT_COUNT-1:0] slot_ff;
   logic [SLOT_COUNT-1:0]    pending_ff;
   logic [SLOT_COUNT-1:0]    pending_in;
   logic [SLOT_COUNT-1:0]    head_oh;
   logic [SLOT_COUNT-1:0]    rest;
   logic                     take;

   assign head_oh   = pending_ff & (~pending_ff + 1'b1);
   assign rest      = pending_ff & ~head_oh;
   assign rsp_valid = (pending_ff != '0);
   assign take      = rsp_valid && !rsp_stall;
   assign rsp_last  = (rest == '0);
   assign free      = !rsp_valid || (take && rsp_last);

   always_comb begin
      rsp_rec = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (head_oh[i]) begin
            rsp_rec = slot_ff[i];
         end
      end
   end

   always_comb begin
      if (load) begin
         pending_in = load_mask;
      end else if (take) begin
         pending_in = rest;
      end else begin
         pending_in = pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_rec;
      end
   end

endmodule

// ===== rtl/peak_hold_coil_sequencer_top.sv =====
// Four-channel peak-and-hold coil sequencer.
// Request channel (req_): one command transaction per cycle when req_stall is low:
//   fire, abort, abort all, comparator trip or a one-microsecond tick.
// Response channel (rsp_): zero to four result transactions per command, in gun
//   order, the final one flagged by rsp_last.
// Register channel (csr_): DAC codes and per-gun default on-times, always ready;
//   write only while the block is idle.
// Command path: a command lands in the input register, is processed once the result
//   buffer is free, while its results are written into the four-slot result
//   buffer, and the first result is presented from that buffer's register.
// Throughput: one command per cycle while each command gives at most one result
//   and the response side does not stall; a command with more results holds the
//   result buffer until the single response port has sent the last of them.
// A stalled response holds its transaction; the input register still takes one
//   more command, then req_stall rises until the buffer drains.
// Reset: all guns idle with drive off, codes zero, default on-times 50 us,
//   both registers empty.
module peak_hold_coil_sequencer_top #(
   parameter int GUN_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_gun,
   input  logic [12:0] req_on_time_ms,
   input  logic        req_system_armed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_gun_index,
   output logic [2:0]  rsp_kind,
   output logic [1:0]  rsp_phase,
   output logic [11:0] rsp_dac_code,
   output logic        rsp_coil_drive,
   output logic        rsp_comp_route,
   output logic        rsp_peak_irq_enable,
   output logic        rsp_peak_seen,
   output logic [22:0] rsp_time_us,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_data
);
   import phc_pkg::*;

   cfg_type                  cfg_ff;
   logic                     item_valid_ff;
   logic                     item_valid_in;
   logic [2:0]               func_ff;
   logic [2:0]               gun_ff;
   logic [12:0]              on_ms_ff;
   logic                     armed_ff;
   logic                     accept;
   logic                     advance;
   logic                     out_free;
   rec_type [SLOT_COUNT-1:0] load_rec;
   logic [SLOT_COUNT-1:0]    load_mask;
   logic [GUN_COUNT-1:0]     busy;
   logic [GUN_COUNT-1:0]     running;
   rec_type                  rsp_rec;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pick <= '0;
         cfg_ff.hold <= '0;
         cfg_ff.nz   <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            cfg_ff.dflt[i] <= MIN_ON_US;
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PICK:  cfg_ff.pick    <= csr_data[CODE_W-1:0];
            CSR_HOLD:  cfg_ff.hold    <= csr_data[CODE_W-1:0];
            CSR_NZ:    cfg_ff.nz      <= csr_data[CODE_W-1:0];
            CSR_DFLT0: cfg_ff.dflt[0] <= csr_data;
            CSR_DFLT1: cfg_ff.dflt[1] <= csr_data;
            CSR_DFLT2: cfg_ff.dflt[2] <= csr_data;
            CSR_DFLT3: cfg_ff.dflt[3] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         gun_ff   <= req_gun;
         on_ms_ff <= req_on_time_ms;
         armed_ff <= req_system_armed;
      end
   end

   phc_core #(
      .GUN_COUNT(GUN_COUNT)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .func        (func_ff),
      .gun         (gun_ff),
      .on_time_ms  (on_ms_ff),
      .system_armed(armed_ff),
      .cfg         (cfg_ff),
      .load_rec    (load_rec),
      .load_mask   (load_mask),
      .busy        (busy),
      .running     (running)
   );

   phc_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .load_rec (load_rec),
      .load_mask(load_mask),
      .free     (out_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_rec  (rsp_rec),
      .rsp_last (rsp_last)
   );

   assign rsp_gun_index       = rsp_rec.gun_index;
   assign rsp_kind            = rsp_rec.kind;
   assign rsp_phase           = rsp_rec.phase;
   assign rsp_dac_code        = rsp_rec.dac_code;
   assign rsp_coil_drive      = rsp_rec.coil_drive;
   assign rsp_comp_route      = rsp_rec.comp_route;
   assign rsp_peak_irq_enable = rsp_rec.peak_irq_enable;
   assign rsp_peak_seen       = rsp_rec.peak_seen;
   assign rsp_time_us         = rsp_rec.time_us;

   a_timer_tracks_phase: assert property (@(posedge clock) disable iff (reset)
      busy == running)
      else $error("timer state disagrees with gun phase");

   a_results_follow_load: assert property (@(posedge clock) disable iff (reset)
      advance && (load_mask != '0) |=> rsp_valid)
      else $error("processed command lost its results");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("result burst ended without last");

endmodule
